// ----- design/sts_pkg.sv -----
// Shared types, constants and fixed-point helpers for the seek steering step block.
// Used by seek_target_steering_step_top, sts_root_div and sts_checker.
package sts_pkg;

  localparam int FRAC_BITS = 16;
  localparam int POS_W     = FRAC_BITS + 1;       // 0..ONE
  localparam int VEC_W     = FRAC_BITS + 2;       // signed -2*ONE..2*ONE-1
  localparam int MAG_W     = FRAC_BITS + 1;       // magnitude operand of the multiplier
  localparam int PROD_W    = 2 * MAG_W;
  localparam int ROOT_W    = MAG_W;               // root and quotient width
  localparam int REM_W     = ROOT_W + 3;
  localparam int STEPS     = ROOT_W;
  localparam int CNT_W     = $clog2(STEPS);
  localparam int DATA_W    = ((2 * POS_W + 7) / 8) * 8;
  localparam int IDX_W     = 2;

  localparam logic [POS_W-1:0] ONE   = POS_W'(64'd1 << FRAC_BITS);
  localparam logic [MAG_W-1:0] TENTH = MAG_W'(((64'd1 << FRAC_BITS) + 64'd5) / 64'd10);
  localparam logic [MAG_W-1:0] K13   = MAG_W'((64'd13 * (64'd1 << FRAC_BITS) + 64'd5) / 64'd10);
  localparam logic [PROD_W:0]  HALF  = (PROD_W+1)'(64'd1 << (FRAC_BITS - 1));

  // Configuration register indexes
  localparam logic [IDX_W-1:0] REG_SPEED = IDX_W'(0);
  localparam logic [IDX_W-1:0] REG_STEER = IDX_W'(1);

  // Request to the shared root/divide unit
  typedef struct packed {
    logic                start;
    logic                is_div;
    logic [PROD_W-1:0]   opnd;   // radicand, or numerator in the low bits
    logic [ROOT_W-1:0]   den;
  } sts_req_t;

  typedef struct packed {
    logic                done;
    logic [ROOT_W-1:0]   res;
  } sts_rsp_t;

  // Saturate an unsigned fraction to one
  function automatic logic [POS_W-1:0] sat_one(input logic [POS_W-1:0] v);
    return (v > ONE) ? ONE : v;
  endfunction

  // Magnitude of a signed vector component
  function automatic logic [MAG_W-1:0] mag(input logic signed [VEC_W-1:0] v);
    logic [VEC_W-1:0] n;
    n = v[VEC_W-1] ? VEC_W'(-v) : VEC_W'(v);
    return n[MAG_W-1:0];
  endfunction

  // Round a Q product to nearest, halves away from zero (on the magnitude)
  function automatic logic [VEC_W-1:0] rnd(input logic [PROD_W-1:0] p);
    logic [PROD_W:0] s;
    s = {1'b0, p} + HALF;
    return s[FRAC_BITS +: VEC_W];
  endfunction

  function automatic logic signed [VEC_W-1:0] signed_of(input logic [VEC_W-1:0] m,
                                                        input logic neg);
    return neg ? $signed(VEC_W'(-m)) : $signed(m);
  endfunction

endpackage

// ----- design/sts_root_div.sv -----
// Shared shift-and-subtract unit: integer square root or restoring division,
// one result bit per cycle. Depends on sts_pkg.
module sts_root_div (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  sts_pkg::sts_req_t req_i,
  output sts_pkg::sts_rsp_t rsp_o
);
  import sts_pkg::*;

  logic              busy_q, done_q, is_div_q;
  logic [CNT_W-1:0]  cnt_q;
  logic [REM_W-1:0]  rem_q;
  logic [ROOT_W-1:0] root_q, den_q;
  logic [PROD_W-1:0] src_q;
  logic [REM_W-1:0]  rem_sh, sub_op;
  logic [REM_W:0]    diff;

  // Shift in the next digit and trial-subtract
  always_comb begin
    if (is_div_q) begin
      rem_sh = {rem_q[REM_W-2:0], src_q[PROD_W-1]};
      sub_op = REM_W'(den_q);
    end else begin
      rem_sh = {rem_q[REM_W-3:0], src_q[PROD_W-1 -: 2]};
      sub_op = REM_W'({root_q, 2'b01});
    end
    diff = {1'b0, rem_sh} - {1'b0, sub_op};
  end

  // Control: start, count steps, flag completion
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + CNT_W'(1);
        if (cnt_q == CNT_W'(STEPS - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // Datapath: load operands, then one digit per cycle
  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      is_div_q <= req_i.is_div;
      den_q    <= req_i.den;
      root_q   <= '0;
      if (req_i.is_div) begin
        rem_q <= REM_W'(req_i.opnd[PROD_W-3:ROOT_W]);
        src_q <= {req_i.opnd[ROOT_W-1:0], {(PROD_W-ROOT_W){1'b0}}};
      end else begin
        rem_q <= '0;
        src_q <= req_i.opnd;
      end
    end else if (busy_q) begin
      src_q <= is_div_q ? {src_q[PROD_W-2:0], 1'b0} : {src_q[PROD_W-3:0], 2'b00};
      if (!diff[REM_W]) begin
        rem_q  <= diff[REM_W-1:0];
        root_q <= {root_q[ROOT_W-2:0], 1'b1};
      end else begin
        rem_q  <= rem_sh;
        root_q <= {root_q[ROOT_W-2:0], 1'b0};
      end
    end
  end

  assign rsp_o.done = done_q;
  assign rsp_o.res  = root_q;

endmodule

// ----- design/seek_target_steering_step_top.sv -----
// Seek steering step: moves a 2-D point toward a target once per input transfer.
// Usage:
//   s_axis carries one target point per transfer; m_axis returns the new
//   position, one transfer per input. cfg_* writes speed_limit (index 0) and
//   steer_limit (index 1); other indexes are ignored. Write config only while
//   the block is idle.
// Operation:
//   A step runs on a small sequencer around one 17x17 multiplier and one
//   shared square-root/divide unit that delivers a bit per cycle (17 steps
//   per root or quotient). Each step takes three roots, and each length
//   limit that applies adds two divisions. The next target is not taken
//   until the current step has finished: s_axis_tready is low while a step
//   is in progress.
// Reset:
//   Position, velocity and acceleration clear to zero; both limits reset to
//   one half. No result is pending.
// Stalls:
//   The result sits in an output register, and the next target is accepted
//   while it waits. A finished step that finds the register still occupied
//   holds until m_axis_tready frees it.
module seek_target_steering_step_top (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      s_axis_tvalid,
  output logic                      s_axis_tready,
  input  logic [sts_pkg::DATA_W-1:0] s_axis_tdata,  // target_x, target_y, zero pad
  output logic                      m_axis_tvalid,
  input  logic                      m_axis_tready,
  output logic [sts_pkg::DATA_W-1:0] m_axis_tdata,  // pos_x, pos_y, zero pad
  input  logic                      cfg_valid_i,
  output logic                      cfg_ready_o,
  input  logic [sts_pkg::IDX_W-1:0] cfg_index_i,
  input  logic [sts_pkg::POS_W-1:0] cfg_data_i
);
  import sts_pkg::*;

  typedef enum logic [4:0] {
    S_IDLE, S_SMAX, S_SQ_D0, S_SQ_D1, S_RT_D, S_WT_D, S_DES, S_DES_W,
    S_SQ_S0, S_SQ_S1, S_RT_S, S_WT_S, S_LIM_MUL, S_LIM_DIV, S_LIM_WT,
    S_ACC, S_ACC_MUL, S_ACC_W, S_VD_MUL, S_VD_W, S_VK_MUL, S_VK_W,
    S_SQ_V0, S_SQ_V1, S_RT_V, S_WT_V, S_POS, S_OUT
  } state_e;

  state_e                  state_q;
  logic                    ix_q, phase_q, neg_q, out_valid_q;
  logic [POS_W-1:0]        spd_q, str_q, pos_q [2];
  logic signed [VEC_W-1:0] vel_q [2], acc_q [2], d_q [2], st_q [2];
  logic [POS_W-1:0]        smax_q, dist_q, len_q;
  logic [PROD_W-1:0]       prod_q, sq_q;
  logic [2*POS_W-1:0]      out_q;

  logic [MAG_W-1:0]        mul_a, mul_b;
  logic                    mul_neg;
  sts_req_t                req;
  sts_rsp_t                rsp;
  logic [POS_W-1:0]        slim, lim, tx, ty;
  logic [VEC_W-1:0]        mrnd;
  logic signed [VEC_W-1:0] vec, mres, acc_sum_c, lim_res;
  logic signed [VEC_W:0]   acc_sum;
  logic signed [VEC_W:0]   psum [2];
  logic [POS_W-1:0]        pnew [2];
  logic                    in_acc, out_acc;

  assign in_acc  = s_axis_tvalid && s_axis_tready;
  assign out_acc = m_axis_tvalid && m_axis_tready;
  assign slim    = sat_one(str_q);
  assign lim     = phase_q ? smax_q : slim;
  assign vec     = phase_q ? vel_q[ix_q] : st_q[ix_q];
  assign mrnd    = rnd(prod_q);
  assign mres    = signed_of(mrnd, neg_q);
  assign lim_res = signed_of(VEC_W'(rsp.res), neg_q);
  assign tx      = sat_one(s_axis_tdata[POS_W-1:0]);
  assign ty      = sat_one(s_axis_tdata[2*POS_W-1:POS_W]);

  // Accumulate steer into acceleration, clamped to plus or minus one
  always_comb begin
    acc_sum = (VEC_W+1)'(acc_q[ix_q]) + (VEC_W+1)'(st_q[ix_q]);
    if (acc_sum > $signed((VEC_W+1)'(ONE)))       acc_sum_c = $signed(VEC_W'(ONE));
    else if (acc_sum < -$signed((VEC_W+1)'(ONE))) acc_sum_c = -$signed(VEC_W'(ONE));
    else                                          acc_sum_c = acc_sum[VEC_W-1:0];
  end

  // Position update, clamped to [0, one]
  always_comb begin
    for (int i = 0; i < 2; i++) begin
      psum[i] = $signed((VEC_W+1)'(pos_q[i])) + (VEC_W+1)'(vel_q[i]);
      if (psum[i] < 0)                               pnew[i] = '0;
      else if (psum[i] > $signed((VEC_W+1)'(ONE)))  pnew[i] = ONE;
      else                                           pnew[i] = psum[i][POS_W-1:0];
    end
  end

  // Select multiplier operands for the current step
  always_comb begin
    mul_a   = '0;
    mul_b   = '0;
    mul_neg = 1'b0;
    case (state_q)
      S_SMAX:    begin mul_a = sat_one(spd_q); mul_b = TENTH; end
      S_SQ_D0:   begin mul_a = mag(d_q[0]); mul_b = mag(d_q[0]); end
      S_SQ_D1:   begin mul_a = mag(d_q[1]); mul_b = mag(d_q[1]); end
      S_DES:     begin mul_a = smax_q; mul_b = mag(d_q[ix_q]); mul_neg = d_q[ix_q] < 0; end
      S_SQ_S0:   begin mul_a = mag(st_q[0]); mul_b = mag(st_q[0]); end
      S_SQ_S1:   begin mul_a = mag(st_q[1]); mul_b = mag(st_q[1]); end
      S_LIM_MUL: begin mul_a = mag(vec); mul_b = lim; mul_neg = vec < 0; end
      S_ACC_MUL: begin
        mul_a = mag(acc_q[ix_q]); mul_b = TENTH; mul_neg = acc_q[ix_q] < 0;
      end
      S_VD_MUL:  begin
        mul_a = mag(vel_q[ix_q]); mul_b = dist_q; mul_neg = vel_q[ix_q] < 0;
      end
      S_VK_MUL:  begin
        mul_a = mag(vel_q[ix_q]); mul_b = K13; mul_neg = vel_q[ix_q] < 0;
      end
      S_SQ_V0:   begin mul_a = mag(vel_q[0]); mul_b = mag(vel_q[0]); end
      S_SQ_V1:   begin mul_a = mag(vel_q[1]); mul_b = mag(vel_q[1]); end
      default:   ;
    endcase
  end

  // Request a root or a quotient from the shared unit
  always_comb begin
    req.start  = 1'b0;
    req.is_div = 1'b0;
    req.opnd   = sq_q + prod_q;
    req.den    = len_q;
    case (state_q)
      S_RT_D, S_RT_S, S_RT_V: req.start = 1'b1;
      S_LIM_DIV: begin
        req.start  = 1'b1;
        req.is_div = 1'b1;
        req.opnd   = prod_q + PROD_W'(len_q >> 1);
      end
      default: ;
    endcase
  end

  sts_root_div u_root_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req),
    .rsp_o  (rsp)
  );

  // Multiplier with registered product
  always_ff @(posedge clk_i) begin
    prod_q <= mul_a * mul_b;
    if (mul_a != '0 || mul_b != '0) neg_q <= mul_neg;
  end

  // Sequencer, state and registered outputs
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      ix_q        <= 1'b0;
      phase_q     <= 1'b0;
      out_valid_q <= 1'b0;
      spd_q       <= POS_W'(32768);
      str_q       <= POS_W'(32768);
      for (int i = 0; i < 2; i++) begin
        pos_q[i] <= '0;
        vel_q[i] <= '0;
        acc_q[i] <= '0;
      end
    end else begin
      if (cfg_valid_i && cfg_ready_o) begin
        unique case (cfg_index_i)
          REG_SPEED: spd_q <= cfg_data_i;
          REG_STEER: str_q <= cfg_data_i;
          default:   ;
        endcase
      end

      // Load a finished result, or drop the one just taken
      if (state_q == S_OUT && (!out_valid_q || m_axis_tready)) out_valid_q <= 1'b1;
      else if (out_acc)                                         out_valid_q <= 1'b0;

      unique case (state_q)
        S_IDLE:  if (in_acc) state_q <= S_SMAX;
        S_SMAX:  state_q <= S_SQ_D0;
        S_SQ_D0: state_q <= S_SQ_D1;
        S_SQ_D1: state_q <= S_RT_D;
        S_RT_D:  state_q <= S_WT_D;
        S_WT_D:  if (rsp.done) begin
          ix_q    <= 1'b0;
          state_q <= S_DES;
        end
        S_DES:   state_q <= S_DES_W;
        S_DES_W: begin
          ix_q    <= ~ix_q;
          state_q <= ix_q ? S_SQ_S0 : S_DES;
        end
        S_SQ_S0: state_q <= S_SQ_S1;
        S_SQ_S1: state_q <= S_RT_S;
        S_RT_S:  state_q <= S_WT_S;
        S_WT_S:  if (rsp.done) begin
          ix_q    <= 1'b0;
          phase_q <= 1'b0;
          state_q <= (rsp.res > slim) ? S_LIM_MUL : S_ACC;
        end
        S_LIM_MUL: state_q <= S_LIM_DIV;
        S_LIM_DIV: state_q <= S_LIM_WT;
        S_LIM_WT:  if (rsp.done) begin
          if (phase_q) vel_q[ix_q] <= lim_res;
          ix_q <= ~ix_q;
          if (!ix_q)        state_q <= S_LIM_MUL;
          else if (phase_q) state_q <= S_POS;
          else              state_q <= S_ACC;
        end
        S_ACC: begin
          acc_q[ix_q] <= acc_sum_c;
          state_q     <= S_ACC_MUL;
        end
        S_ACC_MUL: state_q <= S_ACC_W;
        S_ACC_W: begin
          vel_q[ix_q] <= vel_q[ix_q] + mres;
          state_q     <= S_VD_MUL;
        end
        S_VD_MUL: state_q <= S_VD_W;
        S_VD_W: begin
          vel_q[ix_q] <= mres;
          state_q     <= S_VK_MUL;
        end
        S_VK_MUL: state_q <= S_VK_W;
        S_VK_W: begin
          vel_q[ix_q] <= mres;
          ix_q        <= ~ix_q;
          state_q     <= ix_q ? S_SQ_V0 : S_ACC;
        end
        S_SQ_V0: state_q <= S_SQ_V1;
        S_SQ_V1: state_q <= S_RT_V;
        S_RT_V:  state_q <= S_WT_V;
        S_WT_V:  if (rsp.done) begin
          ix_q    <= 1'b0;
          phase_q <= 1'b1;
          state_q <= (rsp.res > smax_q) ? S_LIM_MUL : S_POS;
        end
        S_POS: begin
          pos_q[0] <= pnew[0];
          pos_q[1] <= pnew[1];
          state_q  <= S_OUT;
        end
        S_OUT: if (!out_valid_q || m_axis_tready) state_q <= S_IDLE;
        default: state_q <= S_IDLE;
      endcase
    end
  end

  // Working values of the current step
  always_ff @(posedge clk_i) begin
    case (state_q)
      S_IDLE: if (in_acc) begin
        d_q[0] <= $signed(VEC_W'(tx)) - $signed(VEC_W'(pos_q[0]));
        d_q[1] <= $signed(VEC_W'(ty)) - $signed(VEC_W'(pos_q[1]));
      end
      S_SQ_D0: smax_q <= mrnd[POS_W-1:0];
      S_SQ_D1, S_SQ_S1, S_SQ_V1: sq_q <= prod_q;
      S_WT_D:  if (rsp.done) dist_q <= rsp.res;
      S_DES_W: st_q[ix_q] <= mres - vel_q[ix_q];
      S_WT_S, S_WT_V: if (rsp.done) len_q <= rsp.res;
      S_LIM_WT: if (rsp.done && !phase_q) st_q[ix_q] <= lim_res;
      S_OUT:   if (!out_valid_q || m_axis_tready) out_q <= {pos_q[1], pos_q[0]};
      default: ;
    endcase
  end

  assign s_axis_tready = (state_q == S_IDLE);
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = DATA_W'(out_q);
  assign cfg_ready_o   = 1'b1;

endmodule

// ----- design/sts_checker.sv -----
// Port-level checks for seek_target_steering_step_top, attached by bind.
// Depends on sts_pkg.
module sts_checker (
  input logic                       clk_i,
  input logic                       rst_ni,
  input logic                       s_axis_tvalid,
  input logic                       s_axis_tready,
  input logic [sts_pkg::DATA_W-1:0] s_axis_tdata,
  input logic                       m_axis_tvalid,
  input logic                       m_axis_tready,
  input logic [sts_pkg::DATA_W-1:0] m_axis_tdata,
  input logic                       cfg_valid_i,
  input logic                       cfg_ready_o,
  input logic [sts_pkg::IDX_W-1:0]  cfg_index_i,
  input logic [sts_pkg::POS_W-1:0]  cfg_data_i
);
  import sts_pkg::*;

  // Hold a stalled result
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("stalled result changed");

  // A step keeps the input closed on the next cycle
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("input open right after a transfer");

  // Positions stay within [0, one]
  a_pos_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> m_axis_tdata[POS_W-1:0] <= ONE
                   && m_axis_tdata[2*POS_W-1:POS_W] <= ONE)
    else $error("position out of range");

  // Padding bits read zero
  a_pad_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> m_axis_tdata[DATA_W-1:2*POS_W] == '0)
    else $error("nonzero pad bits");

endmodule

bind seek_target_steering_step_top sts_checker u_sts_checker (.*);

// ----- sim/tb_top.sv -----
// Testbench for seek_target_steering_step_top: drives target transfers and
// register writes, predicts each new position in a scoreboard class.
// Depends on sts_pkg and the RTL of the block.
`timescale 1ns / 1ps

class steer_scoreboard;
  longint speed_q, steer_q;
  longint pos[2], vel[2], acc[2];
  bit [sts_pkg::POS_W-1:0] want_x[$], want_y[$];
  int errors;

  function new();
    speed_q = 32768;
    steer_q = 32768;
    pos = '{0, 0};
    vel = '{0, 0};
    acc = '{0, 0};
    errors = 0;
  endfunction

  function longint sat1(longint v);
    return (v > 65536) ? 65536 : v;
  endfunction

  function longint clampv(longint v, longint lo, longint hi);
    return v < lo ? lo : (v > hi ? hi : v);
  endfunction

  function longint absv(longint v);
    return v < 0 ? -v : v;
  endfunction

  // Q16 product, rounded half away from zero
  function longint qmul(longint a, longint b);
    longint r;
    r = (absv(a) * absv(b) + 32768) >>> 16;
    return ((a < 0) != (b < 0)) ? -r : r;
  endfunction

  function longint ratio(longint v, longint num, longint den);
    longint r;
    r = (absv(v) * num + den / 2) / den;
    return v < 0 ? -r : r;
  endfunction

  function longint root(longint x);
    longint res, b;
    res = 0;
    b = 64'sd1 << 62;
    while (b > x) b = b >> 2;
    while (b != 0) begin
      if (x >= res + b) begin
        x = x - (res + b);
        res = (res >> 1) + b;
      end else begin
        res = res >> 1;
      end
      b = b >> 2;
    end
    return res;
  endfunction

  function longint hyp(longint a, longint b);
    return root(a * a + b * b);
  endfunction

  function void write_reg(logic [sts_pkg::IDX_W-1:0] idx, longint val);
    if (idx == sts_pkg::REG_SPEED) speed_q = val;
    else if (idx == sts_pkg::REG_STEER) steer_q = val;
  endfunction

  // Advance the state by one target transfer and queue the new position
  function void note_target(longint tx, longint ty);
    longint d[2], st[2], smax, slim, span, slen, vlen, tenth, k13;
    tenth = 6554;
    k13 = 85197;
    smax = qmul(sat1(speed_q), tenth);
    slim = sat1(steer_q);
    d[0] = sat1(tx) - pos[0];
    d[1] = sat1(ty) - pos[1];
    span = hyp(d[0], d[1]);
    for (int i = 0; i < 2; i++) st[i] = qmul(smax, d[i]) - vel[i];
    slen = hyp(st[0], st[1]);
    if (slen > slim)
      for (int i = 0; i < 2; i++) st[i] = ratio(st[i], slim, slen);
    for (int i = 0; i < 2; i++) begin
      acc[i] = clampv(acc[i] + st[i], -65536, 65536);
      vel[i] = vel[i] + qmul(acc[i], tenth);
      vel[i] = qmul(qmul(vel[i], span), k13);
    end
    vlen = hyp(vel[0], vel[1]);
    if (vlen > smax)
      for (int i = 0; i < 2; i++) vel[i] = ratio(vel[i], smax, vlen);
    for (int i = 0; i < 2; i++) pos[i] = clampv(pos[i] + vel[i], 0, 65536);
    want_x.push_back(sts_pkg::POS_W'(pos[0]));
    want_y.push_back(sts_pkg::POS_W'(pos[1]));
  endfunction

  function void report(string msg);
    $display("MISMATCH: %s", msg);
    errors++;
  endfunction

  function void check_position(bit [sts_pkg::POS_W-1:0] px, bit [sts_pkg::POS_W-1:0] py);
    bit [sts_pkg::POS_W-1:0] ex, ey;
    if (want_x.size() == 0) begin
      report($sformatf("unexpected position %0d,%0d", px, py));
      return;
    end
    ex = want_x.pop_front();
    ey = want_y.pop_front();
    if (px !== ex) report($sformatf("pos_x got %0d want %0d", px, ex));
    if (py !== ey) report($sformatf("pos_y got %0d want %0d", py, ey));
  endfunction
endclass

module tb_top;
  import sts_pkg::*;

  logic clk_i = 0;
  logic rst_ni = 0;
  logic s_axis_tvalid = 0;
  logic s_axis_tready;
  logic [DATA_W-1:0] s_axis_tdata = '0;
  logic m_axis_tvalid;
  logic m_axis_tready = 0;
  logic [DATA_W-1:0] m_axis_tdata;
  logic cfg_valid_i = 0;
  logic cfg_ready_o;
  logic [IDX_W-1:0] cfg_index_i = '0;
  logic [POS_W-1:0] cfg_data_i = '0;

  steer_scoreboard sb;
  int send_idle, recv_stall;
  bit hold_off;
  int quiet_cycles;

  seek_target_steering_step_top dut (.*);

  always begin
    #10 clk_i = 1;
    #10 clk_i = 0;
  end

  // Send one target; random gap before offering it, valid stays high after
  task automatic send_target(logic [POS_W-1:0] tx, logic [POS_W-1:0] ty);
    if ($urandom_range(99) < send_idle) begin
      s_axis_tvalid <= 0;
      @(posedge clk_i);
      while ($urandom_range(99) < send_idle) @(posedge clk_i);
    end
    s_axis_tvalid <= 1;
    s_axis_tdata <= DATA_W'({ty, tx});
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    sb.note_target(longint'(tx), longint'(ty));
  endtask

  task automatic write_cfg(logic [IDX_W-1:0] idx, logic [POS_W-1:0] val);
    cfg_valid_i <= 1;
    cfg_index_i <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    sb.write_reg(idx, longint'(val));
    cfg_valid_i <= 0;
    @(posedge clk_i);
  endtask

  // Drop the input and wait for every expected result
  task automatic drain();
    s_axis_tvalid <= 0;
    while (sb.want_x.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
  endtask

  function automatic logic [POS_W-1:0] rand_coord();
    case ($urandom_range(9))
      0: return ONE;
      1: return '0;
      2: return POS_W'($urandom_range(131071));
      default: return POS_W'($urandom_range(65536));
    endcase
  endfunction

  // Receiver: random stalls, plus a long hold-off when requested
  always @(posedge clk_i) begin
    if (m_axis_tvalid && m_axis_tready)
      sb.check_position(m_axis_tdata[POS_W-1:0], m_axis_tdata[2*POS_W-1:POS_W]);
    m_axis_tready <= !hold_off && ($urandom_range(99) >= recv_stall);
  end

  // Watchdog on cycles without any transfer
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        (cfg_valid_i && cfg_ready_o))
      quiet_cycles <= 0;
    else if (++quiet_cycles > 20000) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  initial begin
    int ph_send[4] = '{0, 47, 0, 26};
    int ph_recv[4] = '{0, 0, 47, 26};
    logic [POS_W-1:0] spd[4] = '{ONE, 17'd0, 17'd131071, 17'd40000};
    logic [POS_W-1:0] str[4] = '{17'd0, ONE, 17'd3000, 17'd131071};
    sb = new();
    send_idle = 0;
    recv_stall = 0;
    hold_off = 0;
    quiet_cycles = 0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1;
    @(posedge clk_i);
    // Directed: corners, target reached, out-of-range saturation
    send_target(ONE, ONE);
    send_target(ONE, ONE);
    send_target('0, '0);
    send_target(17'd131071, '0);
    send_target('0, 17'd131071);
    send_target(17'h15555, 17'h0AAAA);
    send_target(17'h0AAAA, 17'h15555);
    send_target(17'd32768, 17'd32768);
    send_target(17'd32768, 17'd32768);
    drain();
    write_cfg(2'd2, 17'd5);
    write_cfg(2'd3, 17'd1);
    // Long hold-off while targets keep coming
    hold_off = 1;
    fork
      begin
        repeat (6) send_target(rand_coord(), rand_coord());
        s_axis_tvalid <= 0;
      end
      begin
        repeat (2000) @(posedge clk_i);
        hold_off = 0;
      end
    join
    drain();
    for (int ph = 0; ph < 4; ph++) begin
      write_cfg(REG_SPEED, spd[ph]);
      write_cfg(REG_STEER, str[ph]);
      send_idle = ph_send[ph];
      recv_stall = ph_recv[ph];
      for (int n = 0; n < 185; n++) send_target(rand_coord(), rand_coord());
      drain();
    end
    write_cfg(REG_SPEED, 17'd32768);
    write_cfg(REG_STEER, 17'd32768);
    drain();
    if (sb.errors == 0 && sb.want_x.size() == 0)
      $display("Test completed successfully");
    else
      $display("Test completed with failures");
    $finish;
  end
endmodule

// ----- filelist.f -----
design/sts_pkg.sv
design/sts_root_div.sv
design/seek_target_steering_step_top.sv
design/sts_checker.sv
sim/tb_top.sv
